>>> hw/rtl/bast_pkg.sv
// Shared types, codes and sizes for the block allocator state table.
// Holds the lifecycle transition function used by the back end.
// No dependencies; imported by every module of the block.
`default_nettype none

package bast_pkg;

    // Store size and derived widths
    localparam int NUM_BLOCKS  = 64;
    localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Fixed field widths of the stream payload
    localparam int KIND_W      = 3;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int STATE_W     = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // Common width that holds both a block number and the index field
    localparam int EXT_W       = (BLK_W > INDEX_W) ? BLK_W : INDEX_W;
    localparam int CMP_W       = EXT_W + 1;

    // Two-level first-free search: groups of eight blocks
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_IDX_W = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS  = (NUM_BLOCKS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int GRANT_W     = GROUP_W + GROUP_IDX_W;
    localparam int SCAN_W      = NUM_GROUPS * GROUP_SIZE;

    // Command queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC_N = 3'd0,
        KIND_ALLOC_T = 3'd1,
        KIND_FREE_N  = 3'd2,
        KIND_FREE_T  = 3'd3,
        KIND_CLEAN   = 3'd4
    } kind_t;

    typedef enum logic [STATE_W-1:0] {
        ST_FREE       = 3'd0,
        ST_ALLOC      = 3'd1,
        ST_TRANS      = 3'd2,
        ST_FREE_OVER  = 3'd3,
        ST_ALLOC_OVER = 3'd4,
        ST_INVALID    = 3'd5
    } blk_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ILLEGAL = 2'd1,
        STATUS_NOBLOCK = 2'd2
    } status_t;

    // Classification made by the front end
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  index;
    } cmd_t;

    // Lifecycle transition; any pair not listed goes to invalid
    function automatic blk_state_t next_state(input blk_state_t cur,
                                              input logic [KIND_W-1:0] kind);
        blk_state_t nxt;
        nxt = ST_INVALID;
        case (cur)
            ST_FREE: begin
                if (kind == KIND_ALLOC_N)      nxt = ST_ALLOC;
                else if (kind == KIND_ALLOC_T) nxt = ST_TRANS;
            end
            ST_ALLOC: begin
                if (kind == KIND_FREE_N) nxt = ST_FREE;
            end
            ST_TRANS, ST_FREE_OVER: begin
                if (kind == KIND_ALLOC_N)                           nxt = ST_ALLOC_OVER;
                else if (kind == KIND_FREE_T || kind == KIND_CLEAN) nxt = ST_FREE;
            end
            ST_ALLOC_OVER: begin
                if (kind == KIND_FREE_N)                            nxt = ST_FREE_OVER;
                else if (kind == KIND_FREE_T || kind == KIND_CLEAN) nxt = ST_ALLOC;
            end
            default: nxt = ST_INVALID;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/block_allocator_state_table_core.sv
// Top level of the block allocator state table.
// Instantiates bast_front, bast_queue and bast_back; depends on bast_pkg.
`default_nettype none

// Storage block allocator. Each request beat carries a kind on s_tuser and a
// block number on s_tdata and produces exactly one result beat on m_tdata:
// status, the granted or targeted block, and that block's lifecycle state after
// the request. Allocates search for the lowest eligible block; frees and cleans
// act on the given block; undefined kinds and blocks outside the store come back
// as illegal with no change. The back end takes one request at a time: its idle
// state pops the queue head and scans the store in groups of eight blocks into
// registers; its apply state picks the lowest group, steps the transition table
// and loads the result register. With the two-level search and single store
// update port, a new request is taken only when the last is through and the
// result slot is free or being taken, for every kind. A two-entry command queue
// and the result register let the request side keep sending while a result waits
// to be taken. Reset clears the flip-flop store at once, so requests go straight in.

module block_allocator_state_table_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bast_pkg::S_TDATA_W-1:0] s_tdata,  // [5:0] block_index
    input  wire logic [bast_pkg::KIND_W-1:0]    s_tuser,  // [2:0] kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [7:2] chosen_block, [10:8] new_block_state
    output logic [bast_pkg::M_TDATA_W-1:0]     m_tdata
);
    import bast_pkg::*;

    // Front to queue
    logic push_valid, push_ready;
    cmd_t push_cmd;
    // Queue to back
    logic pop_valid, pop_ready;
    cmd_t head_cmd;

    // Classify each beat as it arrives
    bast_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Hold classified commands until the back end is free
    bast_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .head_cmd   (head_cmd)
    );

    // Search, update the store and present the result beat
    bast_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .head_cmd  (head_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bast_front.sv
// Front end: takes request beats and classifies them into queue commands.
// Depends on bast_pkg.
`default_nettype none

module bast_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bast_pkg::S_TDATA_W-1:0] s_tdata,  // [5:0] block_index
    input  wire logic [bast_pkg::KIND_W-1:0]    s_tuser,  // [2:0] kind
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output bast_pkg::cmd_t                     push_cmd
);
    import bast_pkg::*;

    logic [INDEX_W-1:0] index;
    logic [CMP_W-1:0]   index_ext;
    logic               in_range;
    cmd_op_t            op;

    assign index     = s_tdata[INDEX_W-1:0];
    assign index_ext = CMP_W'(index);
    assign in_range  = index_ext < CMP_W'(NUM_BLOCKS);

    // Targeted kinds outside the store and undefined kinds are dropped to reject
    always_comb begin
        case (s_tuser)
            KIND_ALLOC_N, KIND_ALLOC_T:           op = CMD_ALLOC;
            KIND_FREE_N, KIND_FREE_T, KIND_CLEAN: op = in_range ? CMD_TARGET : CMD_REJECT;
            default:                              op = CMD_REJECT;
        endcase
    end

    assign push_cmd   = '{op: op, kind: s_tuser, index: index};
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

>>> hw/rtl/bast_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on bast_pkg.
`default_nettype none

module bast_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire bast_pkg::cmd_t push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output bast_pkg::cmd_t      head_cmd
);
    import bast_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bast_back.sv
// Back end: block store, two-step first-free search, state update, result register.
// Depends on bast_pkg.
`default_nettype none

module bast_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire bast_pkg::cmd_t                head_cmd,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bast_pkg::M_TDATA_W-1:0]     m_tdata
);
    import bast_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } back_state_t;

    back_state_t         state_reg;
    cmd_t                cmd_reg;
    logic                grp_any_reg   [NUM_GROUPS];
    logic [GROUP_IDX_W-1:0] grp_first_reg [NUM_GROUPS];
    logic                occ_reg       [NUM_BLOCKS];
    blk_state_t          blk_st_reg    [NUM_BLOCKS];
    logic                out_valid_reg;
    status_t             out_status_reg, out_status_next;
    logic [INDEX_W-1:0]  out_block_reg,  out_block_next;
    blk_state_t          out_state_reg,  out_state_next;

    logic                   do_pop;
    logic [SCAN_W-1:0]      elig;
    logic                   grp_any   [NUM_GROUPS];
    logic [GROUP_IDX_W-1:0] grp_first [NUM_GROUPS];
    logic                   found;
    logic [GRANT_W-1:0]     grant;
    logic [BLK_W-1:0]       grant_blk, target_blk, sel_blk;
    logic [EXT_W-1:0]       grant_ext, target_ext;
    blk_state_t             cur_st, nxt_st;
    logic                   is_free;

    // Take a command only when the result slot is free by the apply cycle
    assign pop_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign do_pop    = pop_valid && pop_ready;

    // Eligibility of each block for the head command's allocate kind
    always_comb begin
        elig = '0;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (head_cmd.kind == KIND_ALLOC_T) begin
                elig[b] = !occ_reg[b];
            end else begin
                elig[b] = !occ_reg[b] || blk_st_reg[b] == ST_TRANS ||
                          blk_st_reg[b] == ST_FREE_OVER;
            end
        end
    end

    // First level: lowest eligible block within each group of eight
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_any[g]   = |elig[g*GROUP_SIZE +: GROUP_SIZE];
            grp_first[g] = '0;
            for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
                if (elig[g*GROUP_SIZE + i]) grp_first[g] = GROUP_IDX_W'(i);
            end
        end
    end

    // Second level: lowest group that has a candidate
    always_comb begin
        found = 1'b0;
        grant = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                found = 1'b1;
                grant = {GROUP_W'(g), grp_first_reg[g]};
            end
        end
    end

    assign grant_blk  = grant[BLK_W-1:0];
    assign grant_ext  = EXT_W'(grant_blk);
    assign target_ext = EXT_W'(cmd_reg.index);
    assign target_blk = target_ext[BLK_W-1:0];
    assign sel_blk    = (cmd_reg.op == CMD_ALLOC) ? grant_blk : target_blk;
    assign cur_st     = blk_st_reg[sel_blk];
    assign nxt_st     = next_state(cur_st, cmd_reg.kind);
    assign is_free    = cmd_reg.kind == KIND_FREE_N || cmd_reg.kind == KIND_FREE_T;

    always_comb begin
        out_status_next = STATUS_ILLEGAL;
        out_block_next  = cmd_reg.index;
        out_state_next  = ST_INVALID;
        case (cmd_reg.op)
            CMD_ALLOC: begin
                if (found) begin
                    out_status_next = (nxt_st == ST_INVALID) ? STATUS_ILLEGAL : STATUS_OK;
                    out_block_next  = grant_ext[INDEX_W-1:0];
                    out_state_next  = nxt_st;
                end else begin
                    out_status_next = STATUS_NOBLOCK;
                    out_block_next  = '0;
                    out_state_next  = ST_FREE;
                end
            end
            CMD_TARGET: begin
                out_status_next = (nxt_st == ST_INVALID) ? STATUS_ILLEGAL : STATUS_OK;
                out_state_next  = nxt_st;
            end
            default: begin
                out_status_next = STATUS_ILLEGAL;
                out_state_next  = ST_INVALID;
            end
        endcase
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    // drop the result beat once it is taken
                    if (m_tready) out_valid_reg <= 1'b0;
                    if (do_pop) begin
                        cmd_reg <= head_cmd;
                        for (int g = 0; g < NUM_GROUPS; g++) begin
                            grp_any_reg[g]   <= grp_any[g];
                            grp_first_reg[g] <= grp_first[g];
                        end
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= out_status_next;
                    out_block_reg  <= out_block_next;
                    out_state_reg  <= out_state_next;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Block store: occupancy and lifecycle per block, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                occ_reg[b]    <= 1'b0;
                blk_st_reg[b] <= ST_FREE;
            end
        end else if (state_reg == S_APPLY) begin
            case (cmd_reg.op)
                CMD_ALLOC: begin
                    if (found) begin
                        blk_st_reg[sel_blk] <= nxt_st;
                        if (nxt_st != ST_INVALID) occ_reg[sel_blk] <= 1'b1;
                    end
                end
                CMD_TARGET: begin
                    blk_st_reg[sel_blk] <= nxt_st;
                    if (is_free) occ_reg[sel_blk] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_state_reg, out_block_reg, out_status_reg});

    a_apply_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY) |-> !out_valid_reg)
        else $error("apply cycle with a result still pending");

    a_apply_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("apply cycle did not load the result register");

    a_ok_not_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STATUS_OK) |-> (out_state_reg != ST_INVALID))
        else $error("success reported with an invalid block state");

    a_noblock_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STATUS_NOBLOCK) |->
        (out_block_reg == '0 && out_state_reg == ST_FREE))
        else $error("no-block result carries a block or state");

endmodule

`default_nettype wire

>>> verif/bast_grant_checker.sv
`timescale 1ns / 100ps
// Result checker for block_allocator_state_table_core: watches both stream channels,
// tracks occupancy and lifecycle per block, and compares every result beat.
// Depends on bast_pkg for sizes, field widths and the kind, state and status codes.

module bast_grant_checker (
    input  wire logic                                             aclk,
    input  wire logic                                             aresetn,
    input  wire logic                                             s_tvalid,
    input  wire logic                                             s_tready,
    input  wire logic [bast_pkg::S_TDATA_W-1:0]                   s_tdata,
    input  wire logic [bast_pkg::KIND_W-1:0]                      s_tuser,
    input  wire logic                                             m_tvalid,
    input  wire logic                                             m_tready,
    input  wire logic [bast_pkg::M_TDATA_W-1:0]                   m_tdata,
    output int                                                    fail_count,
    output int                                                    pending_count,
    output int                                                    ok_count,
    output int                                                    illegal_count,
    output int                                                    noblock_count,
    output logic [bast_pkg::NUM_BLOCKS-1:0]                       occ_view,
    output logic [bast_pkg::NUM_BLOCKS-1:0][bast_pkg::STATE_W-1:0] state_view
);
    import bast_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   blk;
        blk_state_t           state;
    } grant_t;

    grant_t                                 awaited_grants[$];
    logic [NUM_BLOCKS-1:0]                  occupied;
    logic [NUM_BLOCKS-1:0][STATE_W-1:0]     life;

    assign occ_view   = occupied;
    assign state_view = life;

    function automatic blk_state_t lifecycle_after(input blk_state_t cur,
                                                   input logic [KIND_W-1:0] kind);
        blk_state_t nxt;
        nxt = ST_INVALID;
        case (kind)
            KIND_ALLOC_N: begin
                if (cur == ST_FREE)                                 nxt = ST_ALLOC;
                else if (cur == ST_TRANS || cur == ST_FREE_OVER)    nxt = ST_ALLOC_OVER;
            end
            KIND_ALLOC_T: begin
                if (cur == ST_FREE) nxt = ST_TRANS;
            end
            KIND_FREE_N: begin
                if (cur == ST_ALLOC)          nxt = ST_FREE;
                else if (cur == ST_ALLOC_OVER) nxt = ST_FREE_OVER;
            end
            KIND_FREE_T, KIND_CLEAN: begin
                if (cur == ST_TRANS || cur == ST_FREE_OVER) nxt = ST_FREE;
                else if (cur == ST_ALLOC_OVER)              nxt = ST_ALLOC;
            end
            default: nxt = ST_INVALID;
        endcase
        return nxt;
    endfunction

    // Apply one request to the tracked store and return the grant it earns.
    function automatic grant_t serve_request(input logic [KIND_W-1:0] kind,
                                             input logic [INDEX_W-1:0] idx);
        grant_t     g;
        blk_state_t nxt;
        int         b;
        int         hit;
        g.status = STATUS_NOBLOCK;
        g.blk    = '0;
        g.state  = ST_FREE;
        if (kind == KIND_ALLOC_N || kind == KIND_ALLOC_T) begin
            hit = -1;
            for (b = 0; b < NUM_BLOCKS && hit < 0; b++) begin
                if (!occupied[b] || (kind == KIND_ALLOC_N &&
                    (life[b] == ST_TRANS || life[b] == ST_FREE_OVER)))
                    hit = b;
            end
            if (hit >= 0) begin
                nxt = lifecycle_after(blk_state_t'(life[hit]), kind);
                life[hit] = nxt;
                if (nxt != ST_INVALID) occupied[hit] = 1'b1;
                g.status = (nxt == ST_INVALID) ? STATUS_ILLEGAL : STATUS_OK;
                g.blk    = hit[INDEX_W-1:0];
                g.state  = nxt;
            end
        end else if (kind > KIND_CLEAN || idx >= NUM_BLOCKS) begin
            g.status = STATUS_ILLEGAL;
            g.blk    = idx;
            g.state  = ST_INVALID;
        end else begin
            if (kind != KIND_CLEAN) occupied[idx] = 1'b0;
            nxt = lifecycle_after(blk_state_t'(life[idx]), kind);
            life[idx] = nxt;
            g.status = (nxt == ST_INVALID) ? STATUS_ILLEGAL : STATUS_OK;
            g.blk    = idx;
            g.state  = nxt;
        end
        return g;
    endfunction

    always @(posedge aclk) begin : watch_channels
        grant_t                 want;
        logic [STATUS_W-1:0]    got_status;
        logic [INDEX_W-1:0]     got_blk;
        logic [STATE_W-1:0]     got_state;
        got_status = m_tdata[STATUS_W-1:0];
        got_blk    = m_tdata[STATUS_W +: INDEX_W];
        got_state  = m_tdata[STATUS_W+INDEX_W +: STATE_W];
        if (!aresetn) begin
            occupied = '0;
            life     = '0;
            awaited_grants.delete();
            fail_count    = 0;
            ok_count      = 0;
            illegal_count = 0;
            noblock_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                awaited_grants.push_back(serve_request(s_tuser, s_tdata[INDEX_W-1:0]));
            if (m_tvalid && m_tready) begin
                if (awaited_grants.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing outstanding: got status %0d block %0d state %0d",
                             $time, got_status, got_blk, got_state);
                end else begin
                    want = awaited_grants.pop_front();
                    case (want.status)
                        STATUS_OK:      ok_count++;
                        STATUS_ILLEGAL: illegal_count++;
                        default:        noblock_count++;
                    endcase
                    if (want.status !== got_status || want.blk !== got_blk ||
                        want.state !== got_state) begin
                        fail_count++;
                        $display("%0t: result mismatch: expected status %0d block %0d state %0d, got status %0d block %0d state %0d",
                                 $time, want.status, want.blk, want.state,
                                 got_status, got_blk, got_state);
                    end
                end
            end
        end
        pending_count = awaited_grants.size();
    end

endmodule

>>> verif/tb_block_allocator_state_table_core.sv
`timescale 1ns / 100ps
// Top of the block_allocator_state_table_core testbench: clock, reset, request
// stimulus with bursty sending and a patterned result stall, watchdog and verdict.
// Depends on bast_pkg, the block under test and bast_grant_checker.

module tb_block_allocator_state_table_core;
    import bast_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int WORK_ITEMS   = 600;   // shaped traffic after the directed part
    localparam int TAIL_ITEMS   = 100;   // fully random requests at the very end
    localparam int WINDOW_TOP   = 31;    // shaped traffic lives in blocks 0..WINDOW_TOP
    localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 16;

    // Kinds that the block must refuse without touching the store
    localparam logic [KIND_W-1:0]  KIND_UNDEF_LO = 3'd5;
    localparam logic [KIND_W-1:0]  KIND_UNDEF_HI = 3'd7;
    localparam logic [INDEX_W-1:0] TOP_BLOCK     = '1;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_BLOCKY
    } ready_mode_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;   // [5:0] block_index, [7:6] zero
    logic [KIND_W-1:0]      s_tuser  = '0;   // [2:0] kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // [1:0] status, [7:2] block, [10:8] state

    int fail_count;
    int pending_count;
    int ok_count;
    int illegal_count;
    int noblock_count;
    logic [NUM_BLOCKS-1:0]              occ_view;
    logic [NUM_BLOCKS-1:0][STATE_W-1:0] state_view;

    int          burst_left  = 0;
    int          sent_count  = 0;
    int          idle_cycles = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;
    int          mode_left   = 0;
    int          hold_left   = 0;

    block_allocator_state_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bast_grant_checker grant_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .ok_count      (ok_count),
        .illegal_count (illegal_count),
        .noblock_count (noblock_count),
        .occ_view      (occ_view),
        .state_view    (state_view)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Result side: switch between stall styles at random so that back-pressure
    // lands on both the idle and the apply state of the block, with whole
    // stretches of full throughput in between.
    always @(negedge aclk) begin : drive_ready
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                // hold the current level for a random stretch, then flip it
                if (hold_left == 0) begin
                    m_tready  <= ~m_tready;
                    hold_left  = $urandom_range(1, 12);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    // Watchdog: give up once no beat has moved on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_count);
            $display("block_allocator_state_table_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request beat and hold it until the block takes it. Called and
    // returns at a falling edge. A burst ends with an optional gap; valid is
    // only lowered when there is a gap.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-INDEX_W){1'b0}}, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        sent_count++;
    endtask

    function automatic logic [INDEX_W-1:0] any_index();
        int r;
        r = $urandom;
        return r[INDEX_W-1:0];
    endfunction

    // Shape the next request from the tracked store: mostly steps that the
    // lifecycle table allows, so blocks keep cycling through every state,
    // with a little noise that either changes nothing or lands above the
    // working window where it cannot poison the allocation search.
    task automatic pick_request(output logic [KIND_W-1:0] kind,
                                output logic [INDEX_W-1:0] idx);
        int  dice;
        int  r;
        int  b;
        int  tries;
        int  lo_n;
        int  lo_t;
        int  in_use;
        bit  alloc_n_ok;
        bit  alloc_t_ok;
        lo_n   = -1;
        lo_t   = -1;
        in_use = 0;
        for (b = NUM_BLOCKS - 1; b >= 0; b--) begin
            if (!occ_view[b]) lo_t = b;
            if (!occ_view[b] || state_view[b] == ST_TRANS || state_view[b] == ST_FREE_OVER)
                lo_n = b;
            if (b <= WINDOW_TOP && occ_view[b]) in_use++;
        end
        alloc_n_ok = (lo_n >= 0) && (state_view[lo_n] == ST_FREE ||
                     state_view[lo_n] == ST_TRANS || state_view[lo_n] == ST_FREE_OVER);
        alloc_t_ok = (lo_t >= 0) && (state_view[lo_t] == ST_FREE);

        idx  = any_index();
        dice = $urandom_range(0, 99);
        if (dice < 4) begin
            r    = $urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI);
            kind = r[KIND_W-1:0];
        end else if (dice < 8) begin
            r    = $urandom_range(KIND_FREE_N, KIND_CLEAN);
            kind = r[KIND_W-1:0];
            r    = $urandom_range(WINDOW_TOP + 1, NUM_BLOCKS - 2);
            idx  = r[INDEX_W-1:0];
        end else if ((alloc_n_ok || alloc_t_ok) &&
                     $urandom_range(0, 99) < ((in_use < 20) ? 55 : 25)) begin
            if (alloc_t_ok && (!alloc_n_ok || $urandom_range(0, 1) == 1))
                kind = KIND_ALLOC_T;
            else
                kind = KIND_ALLOC_N;
        end else begin
            // hunt for a block in the window that has a legal next step;
            // fall back to an undefined kind if none turns up
            kind = KIND_UNDEF_LO;
            for (tries = 0; tries < 8 && kind == KIND_UNDEF_LO; tries++) begin
                b    = $urandom_range(0, WINDOW_TOP);
                dice = $urandom_range(0, 99);
                case (state_view[b])
                    ST_ALLOC:      kind = (dice < 2) ? KIND_CLEAN : KIND_FREE_N;
                    ST_TRANS:      kind = (dice < 5) ? KIND_CLEAN : KIND_FREE_T;
                    ST_FREE_OVER:  kind = (dice < 50) ? KIND_CLEAN : KIND_FREE_T;
                    ST_ALLOC_OVER: kind = (dice < 60) ? KIND_FREE_N :
                                          (dice < 90) ? KIND_CLEAN : KIND_FREE_T;
                    default: ;
                endcase
                idx = b[INDEX_W-1:0];
            end
        end
    endtask

    initial begin : run_test
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] idx;
        int                 r;
        int                 n;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill the whole store before any block can go invalid: transparent
        // allocates take every block, one more finds nothing; normal
        // allocates then convert every transparent block, one more finds nothing.
        repeat (NUM_BLOCKS + 1) send_request(KIND_ALLOC_T, any_index());
        repeat (NUM_BLOCKS + 1) send_request(KIND_ALLOC_N, any_index());

        // Directed walk over the table, starting from a store that is all
        // allocated-overwritten. The failing allocate is steered to the top
        // block so the invalid entry it leaves sits above the shaped traffic's window.
        send_request(KIND_FREE_N,   TOP_BLOCK);   // alloc_over -> free_over, unoccupied
        send_request(KIND_ALLOC_T,  any_index()); // free_over refuses transparent alloc
        send_request(KIND_ALLOC_N,  any_index()); // invalid stays invalid
        send_request(KIND_CLEAN,    TOP_BLOCK);
        send_request(KIND_UNDEF_LO, 6'd0);        // undefined kinds change nothing
        send_request(KIND_UNDEF_HI, TOP_BLOCK);
        send_request(KIND_CLEAN,    6'd0);        // alloc_over -> alloc
        send_request(KIND_FREE_N,   6'd0);        // alloc -> free
        send_request(KIND_ALLOC_T,  any_index()); // free -> trans on block 0
        send_request(KIND_CLEAN,    6'd0);        // trans -> free, still occupied
        send_request(KIND_FREE_N,   6'd1);
        send_request(KIND_ALLOC_N,  any_index()); // free_over -> alloc_over
        send_request(KIND_FREE_T,   6'd1);        // alloc_over -> alloc, unoccupied
        send_request(KIND_FREE_N,   6'd1);
        send_request(KIND_ALLOC_N,  any_index()); // free -> alloc
        send_request(KIND_FREE_N,   6'd2);
        send_request(KIND_FREE_T,   6'd2);        // free_over -> free
        send_request(KIND_ALLOC_T,  any_index());
        send_request(KIND_ALLOC_N,  any_index()); // occupied trans -> alloc_over
        send_request(KIND_FREE_N,   6'd3);
        send_request(KIND_CLEAN,    6'd3);        // free_over -> free
        send_request(KIND_ALLOC_T,  any_index());
        send_request(KIND_FREE_T,   6'd3);        // trans -> free
        send_request(KIND_CLEAN,    6'd1);        // alloc refuses clean

        // Shaped random traffic
        for (n = 0; n < WORK_ITEMS; n++) begin
            pick_request(kind, idx);
            send_request(kind, idx);
        end

        // Anything goes: every kind, every block
        for (n = 0; n < TAIL_ITEMS; n++) begin
            r    = $urandom;
            kind = r[KIND_W-1:0];
            send_request(kind, any_index());
        end

        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests over a %0d-block store, from full fill through random churn.",
                 sent_count, NUM_BLOCKS);
        $display("Results: %0d clean steps, %0d refused as illegal, %0d with no block free.",
                 ok_count, illegal_count, noblock_count);
        if (fail_count == 0)
            $display("block_allocator_state_table_core verification clean");
        else
            $display("block_allocator_state_table_core verification failed");
        $finish;
    end

endmodule
